/* rtl/aip_pkg.sv */
// shared types, constants and digit decode for the ascii integer parser
`default_nettype none

package aip_pkg;

  localparam int unsigned OffsetBitsDef = 16;
  localparam int unsigned RadixW        = 6;
  localparam int unsigned ChW           = 8;
  localparam int unsigned ValueW        = 64;
  localparam int unsigned EndOffW       = 16;
  localparam int unsigned DigitW        = 7;
  localparam int unsigned ProdW         = ValueW + RadixW;
  localparam int unsigned OutDataW      = ValueW + EndOffW;
  localparam int unsigned OutUserW      = 2;
  localparam int unsigned ConvBit       = 0;
  localparam int unsigned OvfBit        = 1;

  localparam logic [DigitW-1:0] NoDigit  = 7'd99;
  localparam logic [DigitW-1:0] HexLimit = 7'd16;

  localparam logic [ValueW-1:0] Uint64Max = {ValueW{1'b1}};
  localparam logic [ValueW-1:0] Int64Max  = {1'b0, {(ValueW-1){1'b1}}};

  localparam logic [RadixW-1:0] BaseAuto = 6'd0;
  localparam logic [RadixW-1:0] Base8    = 6'd8;
  localparam logic [RadixW-1:0] Base10   = 6'd10;
  localparam logic [RadixW-1:0] Base16   = 6'd16;

  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChCr    = 8'h0D;
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChPlus  = 8'h2B;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChUpA   = 8'h41;
  localparam logic [ChW-1:0] ChUpX   = 8'h58;
  localparam logic [ChW-1:0] ChUpZ   = 8'h5A;
  localparam logic [ChW-1:0] ChLowA  = 8'h61;
  localparam logic [ChW-1:0] ChLowX  = 8'h78;
  localparam logic [ChW-1:0] ChLowZ  = 8'h7A;
  localparam logic [ChW-1:0] LetterBase = 8'd10;

  typedef enum logic [0:0] {
    RegRadix  = 1'b0,
    RegSigned = 1'b1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    PhDone   = 6'b000001,
    PhSpace  = 6'b000010,
    PhSigned = 6'b000100,
    PhZero   = 6'b001000,
    PhPrefix = 6'b010000,
    PhDigits = 6'b100000
  } phase_e;

  function automatic logic [DigitW-1:0] digit_of(input logic [ChW-1:0] c);
    logic [DigitW-1:0] d;
    if (c >= ChZero && c <= ChNine) begin
      d = DigitW'(c - ChZero);
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = DigitW'(c - ChUpA + LetterBase);
    end else if (c >= ChLowA && c <= ChLowZ) begin
      d = DigitW'(c - ChLowA + LetterBase);
    end else begin
      d = NoDigit;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/ascii_integer_parser.sv */
// ascii string to 64-bit integer parser, one byte per transfer
//
// s_axis carries one byte of a string in tdata, tuser marks the first byte
// of a new string. leading whitespace, an optional sign and an optional 0x
// prefix are taken, then digits of the configured radix (0 = auto base).
// the first byte that is not a digit, a nul or an overflowing digit ends the string and gives
// one result transfer on m_axis: value, end offset, converted and overflow.
// later bytes give nothing until the next first byte.
// cfg writes radix (index 0) and signed_flavour (index 1); cfg is always
// ready; the user must write it only while the parser is idle, the block does not enforce this.
// each byte is held in the input register; the digit step (one
// 64x6 multiply-add with overflow check) runs between that register and
// the result register. throughput is one byte per cycle unless a held result
// stalls the input, set by the single multiply-add stage.
// when the receiver stalls with a result held, the input register holds
// its byte and s_axis takes at most one more byte before tready falls.
// reset clears the parser to wait for a new string, radix 0, unsigned.
`default_nettype none

module ascii_integer_parser #(
  parameter int unsigned OFFSET_BITS = aip_pkg::OffsetBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [0:0]                           cfg_index_i,
  input  wire logic [aip_pkg::RadixW-1:0]           cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  input  wire logic [aip_pkg::ChW-1:0]              s_axis_tdata,  // ch
  input  wire logic [0:0]                           s_axis_tuser,  // first_char
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output      logic [aip_pkg::OutDataW-1:0]         m_axis_tdata,  // value, end_offset
  output      logic [aip_pkg::OutUserW-1:0]         m_axis_tuser   // converted, overflow
);

  localparam logic [OFFSET_BITS-1:0] PosMax = {OFFSET_BITS{1'b1}};

  // configuration
  logic [aip_pkg::RadixW-1:0] radix_q;
  logic                       signed_q;

  // input register
  logic                    in_valid_q;
  logic [aip_pkg::ChW-1:0] in_ch_q;
  logic                    in_first_q;

  // parse state
  aip_pkg::phase_e            phase_q, phase_d, ph_e;
  logic [aip_pkg::ValueW-1:0] acc_q, acc_d, acc_e;
  logic [aip_pkg::RadixW-1:0] base_q, base_d, base_e;
  logic                       neg_q, neg_d, neg_e;
  logic                       any_q, any_d, any_e;
  logic [OFFSET_BITS-1:0]     pos_q, pos_d, pos_e;

  // result register
  logic                        out_valid_q;
  logic [aip_pkg::ValueW-1:0]  out_value_q;
  logic [aip_pkg::EndOffW-1:0] out_off_q;
  logic                        out_conv_q;
  logic                        out_ovf_q;

  logic                        advance;
  logic                        emit;
  logic [aip_pkg::ValueW-1:0]  res_value;
  logic [OFFSET_BITS-1:0]      res_pos;
  logic [aip_pkg::EndOffW-1:0] res_off;
  logic                        res_conv;
  logic                        res_ovf;

  logic [aip_pkg::DigitW-1:0] digit;
  logic [aip_pkg::RadixW-1:0] first_base, take_base;
  logic [aip_pkg::ProdW-1:0]  prod;
  logic                       digit_ok, prod_ovf;
  logic                       is_space, is_sign, is_minus, is_x, radix_auto, zero_lead;
  logic                       use_digit;
  logic [OFFSET_BITS+aip_pkg::EndOffW-1:0] off_ext;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_off_q, out_value_q};
  assign m_axis_tuser  = {out_ovf_q, out_conv_q};

  // byte classes
  assign digit      = aip_pkg::digit_of(in_ch_q);
  assign is_space   = (in_ch_q == aip_pkg::ChSpace) ||
                      (in_ch_q >= aip_pkg::ChTab && in_ch_q <= aip_pkg::ChCr);
  assign is_minus   = (in_ch_q == aip_pkg::ChMinus);
  assign is_sign    = (in_ch_q == aip_pkg::ChPlus) || is_minus;
  assign is_x       = (in_ch_q == aip_pkg::ChLowX) || (in_ch_q == aip_pkg::ChUpX);
  assign radix_auto = (radix_q == aip_pkg::BaseAuto);
  assign zero_lead  = (in_ch_q == aip_pkg::ChZero) &&
                      (radix_auto || radix_q == aip_pkg::Base16);
  assign first_base = radix_auto ? aip_pkg::Base10 : radix_q;

  // state as seen by this byte, a first byte restarts the string
  assign ph_e   = in_first_q ? aip_pkg::PhSpace : phase_q;
  assign acc_e  = in_first_q ? '0 : acc_q;
  assign base_e = in_first_q ? '0 : base_q;
  assign neg_e  = in_first_q ? 1'b0 : neg_q;
  assign any_e  = in_first_q ? 1'b0 : any_q;
  assign pos_e  = in_first_q ? '0 : pos_q;

  // digit step, overflow when the product leaves 64 bits
  assign take_base = (ph_e == aip_pkg::PhSpace || ph_e == aip_pkg::PhSigned) ?
                     first_base : base_e;
  assign digit_ok  = (take_base != '0) && (digit < {1'b0, take_base});
  assign prod      = aip_pkg::ProdW'(acc_e) * aip_pkg::ProdW'(take_base) +
                     aip_pkg::ProdW'(digit);
  assign prod_ovf  = |prod[aip_pkg::ProdW-1:aip_pkg::ValueW];

  always_comb begin
    phase_d   = ph_e;
    acc_d     = acc_e;
    base_d    = base_e;
    neg_d     = neg_e;
    any_d     = any_e;
    pos_d     = (pos_e != PosMax) ? pos_e + 1'b1 : pos_e;
    emit      = 1'b0;
    use_digit = 1'b0;
    res_value = '0;
    res_pos   = '0;
    res_conv  = 1'b0;
    res_ovf   = 1'b0;

    unique case (ph_e)
      aip_pkg::PhDone: begin
        pos_d = pos_e;
      end
      aip_pkg::PhSpace, aip_pkg::PhSigned: begin
        if (ph_e == aip_pkg::PhSpace && is_space) begin
          phase_d = aip_pkg::PhSpace;
        end else if (ph_e == aip_pkg::PhSpace && is_sign) begin
          neg_d   = is_minus;
          phase_d = aip_pkg::PhSigned;
        end else if (zero_lead) begin
          base_d  = radix_auto ? aip_pkg::Base8 : aip_pkg::Base16;
          acc_d   = '0;
          any_d   = 1'b1;
          phase_d = aip_pkg::PhZero;
        end else begin
          use_digit = 1'b1;
        end
      end
      aip_pkg::PhZero: begin
        if (is_x) begin
          base_d  = aip_pkg::Base16;
          phase_d = aip_pkg::PhPrefix;
        end else begin
          use_digit = 1'b1;
        end
      end
      aip_pkg::PhPrefix: begin
        if (digit < aip_pkg::HexLimit) begin
          acc_d   = aip_pkg::ValueW'(digit);
          phase_d = aip_pkg::PhDigits;
        end else begin
          // prefix with no hex digit converts the leading zero only
          emit     = 1'b1;
          phase_d  = aip_pkg::PhDone;
          res_pos  = (pos_e == PosMax) ? PosMax : pos_e - 1'b1;
          res_conv = 1'b1;
        end
      end
      aip_pkg::PhDigits: begin
        use_digit = 1'b1;
      end
      default: begin
        phase_d = aip_pkg::PhDone;
        pos_d   = pos_e;
      end
    endcase

    if (use_digit) begin
      base_d  = take_base;
      phase_d = aip_pkg::PhDigits;
      if (!digit_ok) begin
        emit      = 1'b1;
        phase_d   = aip_pkg::PhDone;
        res_value = any_e ? (neg_e ? (~acc_e + 1'b1) : acc_e) : '0;
        res_pos   = any_e ? pos_e : '0;
        res_conv  = any_e;
      end else if (prod_ovf) begin
        emit      = 1'b1;
        phase_d   = aip_pkg::PhDone;
        res_value = signed_q ? aip_pkg::Int64Max : aip_pkg::Uint64Max;
        res_conv  = 1'b1;
        res_ovf   = 1'b1;
      end else begin
        acc_d = prod[aip_pkg::ValueW-1:0];
        any_d = 1'b1;
      end
    end
  end

  assign off_ext = {{aip_pkg::EndOffW{1'b0}}, res_pos};
  assign res_off = off_ext[aip_pkg::EndOffW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= aip_pkg::BaseAuto;
      signed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (aip_pkg::cfg_reg_e'(cfg_index_i))
        aip_pkg::RegRadix:  radix_q  <= cfg_data_i;
        aip_pkg::RegSigned: signed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch_q    <= s_axis_tdata;
      in_first_q <= s_axis_tuser[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= aip_pkg::PhDone;
      acc_q   <= '0;
      base_q  <= '0;
      neg_q   <= 1'b0;
      any_q   <= 1'b0;
      pos_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      neg_q   <= neg_d;
      any_q   <= any_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_value_q <= res_value;
      out_off_q   <= res_off;
      out_conv_q  <= res_conv;
      out_ovf_q   <= res_ovf;
    end
  end

  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[aip_pkg::OvfBit] |->
      m_axis_tuser[aip_pkg::ConvBit] &&
      m_axis_tdata[aip_pkg::OutDataW-1:aip_pkg::ValueW] == '0)
    else $error("overflow result without converted flag or with nonzero offset");

  a_noconv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[aip_pkg::ConvBit] |->
      m_axis_tdata == '0 && !m_axis_tuser[aip_pkg::OvfBit])
    else $error("unconverted result with nonzero value or offset");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without a blocked result");

  a_done_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> phase_q == aip_pkg::PhDone && out_valid_q)
    else $error("parser not done after giving a result");

endmodule

`default_nettype wire

/* tb/sv/ascii_integer_parser_tb.sv */
// self-checking testbench for the ascii integer parser: byte strings checked against a predictor
module ascii_integer_parser_tb;
  import aip_pkg::*;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned RandomBytes = 1600;
  localparam int unsigned NotDigit    = 99;
  localparam int unsigned WideW       = ValueW + RadixW + 2;
  localparam logic [EndOffW-1:0] OffMax = {EndOffW{1'b1}};

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           first;
  } str_byte_t;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [EndOffW-1:0] end_off;
    logic               conv;
    logic               ovf;
  } parse_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [0:0]          cfg_index_i   = '0;
  logic [RadixW-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ChW-1:0]      s_axis_tdata  = '0;  // ch
  logic [0:0]          s_axis_tuser  = '0;  // first_char
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // value, end_offset
  logic [OutUserW-1:0] m_axis_tuser;        // converted, overflow

  // predictor state
  phase_e             ph         = PhDone;
  logic [ValueW-1:0]  acc        = '0;
  logic [RadixW-1:0]  cur_base   = '0;
  logic               neg        = 1'b0;
  logic               seen_digit = 1'b0;
  logic [EndOffW-1:0] pos        = '0;
  logic [RadixW-1:0]  radix_cfg  = BaseAuto;
  logic               signed_cfg = 1'b0;

  parse_result_t expected_results [$];
  str_byte_t     pending_bytes [$];
  int unsigned   errors     = 0;
  int unsigned   cycles     = 0;
  int unsigned   bytes_made = 0;
  int unsigned   send_gap   = 0;
  int unsigned   stall_left = 0;
  bit            calm       = 1'b0;
  bit            new_str    = 1'b0;

  int unsigned radix_plan [NumPhases] = '{0, 10, 16, 0, 1, 36, 63, 2, 8, 37, 0, 10};
  int unsigned signed_plan [NumPhases] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 0};

  ascii_integer_parser DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned digit_val(input logic [ChW-1:0] c);
    if (c >= ChZero && c <= ChNine) return 32'(c - ChZero);
    if (c >= ChUpA && c <= ChUpZ) return 32'(c - ChUpA) + 10;
    if (c >= ChLowA && c <= ChLowZ) return 32'(c - ChLowA) + 10;
    return NotDigit;
  endfunction

  function automatic void finish_string(input logic [ValueW-1:0] v,
                                        input logic [EndOffW-1:0] off,
                                        input logic conv, input logic ovf);
    expected_results.push_back(parse_result_t'{v, off, conv, ovf});
    ph = PhDone;
  endfunction

  function automatic void digit_step(input logic [ChW-1:0] c, input logic [EndOffW-1:0] idx);
    int unsigned d;
    logic [WideW-1:0] wide;
    d = digit_val(c);
    ph = PhDigits;
    if (cur_base == 0 || d >= cur_base) begin
      finish_string(seen_digit ? (neg ? -acc : acc) : '0, seen_digit ? idx : '0,
                    seen_digit, 1'b0);
      return;
    end
    wide = WideW'(acc) * WideW'(cur_base) + WideW'(d);
    if (wide[WideW-1:ValueW] != '0) begin
      finish_string(signed_cfg ? Int64Max : Uint64Max, '0, 1'b1, 1'b1);
    end else begin
      acc = wide[ValueW-1:0];
      seen_digit = 1'b1;
    end
  endfunction

  function automatic void first_step(input logic [ChW-1:0] c, input logic [EndOffW-1:0] idx);
    if (c == ChZero && (radix_cfg == BaseAuto || radix_cfg == Base16)) begin
      cur_base = (radix_cfg == BaseAuto) ? Base8 : Base16;
      acc = '0;
      seen_digit = 1'b1;
      ph = PhZero;
    end else begin
      cur_base = (radix_cfg == BaseAuto) ? Base10 : radix_cfg;
      digit_step(c, idx);
    end
  endfunction

  function automatic void parse_byte(input logic [ChW-1:0] c, input logic first);
    logic [EndOffW-1:0] idx;
    if (first) begin
      ph = PhSpace;
      acc = '0;
      cur_base = '0;
      neg = 1'b0;
      seen_digit = 1'b0;
      pos = '0;
    end
    if (ph == PhDone) return;
    idx = pos;
    if (pos != OffMax) pos++;
    case (ph)
      PhSpace: begin
        if (!(c == ChSpace || (c >= ChTab && c <= ChCr))) begin
          if (c == ChPlus || c == ChMinus) begin
            neg = (c == ChMinus);
            ph = PhSigned;
          end else begin
            first_step(c, idx);
          end
        end
      end
      PhSigned: first_step(c, idx);
      PhZero: begin
        if (c == ChLowX || c == ChUpX) begin
          cur_base = Base16;
          ph = PhPrefix;
        end else begin
          digit_step(c, idx);
        end
      end
      PhPrefix: begin
        if (digit_val(c) < 16) begin
          acc = ValueW'(digit_val(c));
          ph = PhDigits;
        end else begin
          finish_string('0, (idx == OffMax) ? OffMax : idx - 1'b1, 1'b1, 1'b0);
        end
      end
      default: digit_step(c, idx);
    endcase
  endfunction

  function automatic void push_byte(input logic [ChW-1:0] c);
    pending_bytes.push_back(str_byte_t'{c, new_str});
    new_str = 1'b0;
    bytes_made++;
  endfunction

  function automatic void push_text(input string s);
    new_str = 1'b1;
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [ChW-1:0] digit_char(input int unsigned d);
    if (d < 10) return ChW'(ChZero + d);
    return ChW'(($urandom_range(0, 1) ? ChUpA : ChLowA) + (d - 10));
  endfunction

  function automatic void push_digits(input logic [ValueW-1:0] v, input int unsigned b);
    logic [ChW-1:0] rev [$];
    do begin
      rev.push_front(digit_char(32'(v % b)));
      v = v / b;
    end while (v != 0);
    foreach (rev[i]) push_byte(rev[i]);
  endfunction

  // optional whitespace, sign and prefix, digits of the base, then an optional terminator
  function automatic void push_string();
    int unsigned b;
    int unsigned n;
    int unsigned sel;
    int unsigned dmax;
    int unsigned d;
    new_str = 1'b1;
    b = 32'(radix_cfg);
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      sel = $urandom_range(0, 5);
      push_byte(sel == 5 ? ChSpace : ChW'(ChTab + sel));
    end
    sel = $urandom_range(0, 3);
    if (sel == 0) push_byte(ChPlus);
    else if (sel == 1) push_byte(ChMinus);
    if (b == BaseAuto || b == Base16) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
        push_byte(ChZero);
        push_byte($urandom_range(0, 1) ? ChLowX : ChUpX);
        b = 32'(Base16);
      end else if (sel == 1 && b == BaseAuto) begin
        push_byte(ChZero);
        b = 32'(Base8);
      end else if (b == BaseAuto) begin
        b = 32'(Base10);
      end
    end
    dmax = (b > 36) ? 35 : b - 1;
    sel = $urandom_range(0, 9);
    if (sel >= 8 && b >= 2) begin
      if (sel == 8) begin
        push_digits(Uint64Max / b, b);
        d = 32'(Uint64Max % b) + $urandom_range(0, 1);
      end else begin
        push_digits(Uint64Max - $urandom_range(0, 1), b);
        d = $urandom_range(0, dmax);
      end
      if (d <= dmax && $urandom_range(0, 3) != 0) push_byte(digit_char(d));
    end else begin
      n = (sel == 7) ? $urandom_range(15, 25) : $urandom_range(0, 6);
      repeat (n) push_byte(digit_char($urandom_range(0, dmax)));
    end
    sel = $urandom_range(0, 5);
    if (sel == 0) begin
      push_byte(8'h00);
    end else if (sel == 1) begin
      push_byte(ChSpace);
    end else if (sel <= 3) begin
      push_byte(ChW'($urandom_range(0, 255)));
    end else if (sel == 5) begin
      push_byte(8'h00);
      repeat ($urandom_range(1, 3)) push_byte(ChW'($urandom_range(0, 255)));
    end
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [RadixW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegRadix) radix_cfg = val;
    else signed_cfg = val[0];
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // byte driver, prediction on each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    str_byte_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) parse_byte(s_axis_tdata, s_axis_tuser[0]);
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        s_axis_tdata  <= nxt.ch;
        s_axis_tuser  <= nxt.first;
        s_axis_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 6);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: value %h", m_axis_tdata[ValueW-1:0]);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[ValueW-1:0] !== want.value) begin
            $error("value: expected %h, got %h", want.value, m_axis_tdata[ValueW-1:0]);
            errors++;
          end
          if (m_axis_tdata[OutDataW-1:ValueW] !== want.end_off) begin
            $error("end_offset: expected %0d, got %0d", want.end_off,
                   m_axis_tdata[OutDataW-1:ValueW]);
            errors++;
          end
          if (m_axis_tuser[ConvBit] !== want.conv) begin
            $error("converted: expected %b, got %b", want.conv, m_axis_tuser[ConvBit]);
            errors++;
          end
          if (m_axis_tuser[OvfBit] !== want.ovf) begin
            $error("overflow: expected %b, got %b", want.ovf, m_axis_tuser[OvfBit]);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ascii_integer_parser_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned goal;
    radix_plan[10]  = $urandom_range(0, 63);
    signed_plan[10] = $urandom_range(0, 1);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed strings at the reset settings
    new_str = 1'b0;
    push_byte(8'h35);
    push_text("\t+017 ");
    push_text("-0xg");
    push_text("0XfF");
    push_byte(8'h00);
    push_text("abc");
    push_byte(8'hFF);
    push_text("12");
    push_text("7");
    push_byte(8'h00);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_reg(RegRadix, RadixW'(radix_plan[p]));
      write_reg(RegSigned, RadixW'(signed_plan[p]));
      @(negedge clk_i);
      calm = (p >= NumPhases - 2);
      goal = bytes_made + RandomBytes / NumPhases;
      while (bytes_made < goal) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            new_str = ($urandom_range(0, 3) == 0);
            push_byte(ChW'($urandom_range(0, 255)));
          end
        end else begin
          push_string();
        end
      end
    end
    drain();

    if (errors == 0) $display("ascii_integer_parser_tb OK");
    else $display("ascii_integer_parser_tb NOT OK");
    $finish;
  end

endmodule
